// ----- rtl/rrct_pkg.sv -----
package rrct_pkg;

  // Field widths fixed by the interface.
  localparam int TIME_IN_W = 16;
  localparam int JOB_W     = 5;
  localparam int COMP_W    = 20;
  localparam int DIFF_W    = 21;
  localparam int TOT_W     = 25;

  localparam int DEF_MAX_JOBS = 16;
  localparam logic [TIME_IN_W-1:0] QUANTUM_RESET = 16'd4;

  // Microprogram addresses.
  localparam int STEP_W = 3;
  localparam logic [STEP_W-1:0] ST_LOAD     = 3'd0;
  localparam logic [STEP_W-1:0] ST_INIT     = 3'd1;
  localparam logic [STEP_W-1:0] ST_TURN_RD  = 3'd2;
  localparam logic [STEP_W-1:0] ST_TURN_EX  = 3'd3;
  localparam logic [STEP_W-1:0] ST_OUT_RD   = 3'd4;
  localparam logic [STEP_W-1:0] ST_OUT_DIFF = 3'd5;
  localparam logic [STEP_W-1:0] ST_OUT_EMIT = 3'd6;
  localparam logic [STEP_W-1:0] ST_FINISH   = 3'd7;

  // Jump conditions: the jump is taken when the condition holds.
  localparam int JC_W = 3;
  localparam logic [JC_W-1:0] JC_NEXT      = 3'd0;
  localparam logic [JC_W-1:0] JC_ALWAYS    = 3'd1;
  localparam logic [JC_W-1:0] JC_NOT_CLOSE = 3'd2;
  localparam logic [JC_W-1:0] JC_TURNS     = 3'd3;
  localparam logic [JC_W-1:0] JC_OUTS      = 3'd4;

  typedef struct packed {
    logic              busy;
    logic              load;
    logic              init;
    logic              turn;
    logic              diff;
    logic              emit;
    logic              clear;
    logic [JC_W-1:0]   jcond;
    logic [STEP_W-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic load_close;
    logic turns_left;
    logic outs_left;
  } status_t;

  // Control store: one word per step.
  function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
    ctrl_t w;
    w = '0;
    w.busy = 1'b1;
    w.jcond = JC_NEXT;
    w.target = ST_LOAD;
    case (step)
      ST_LOAD: begin
        w.busy = 1'b0;
        w.load = 1'b1;
        w.jcond = JC_NOT_CLOSE;
        w.target = ST_LOAD;
      end
      ST_INIT: begin
        w.init = 1'b1;
      end
      ST_TURN_RD: begin
        w.jcond = JC_NEXT;
      end
      ST_TURN_EX: begin
        w.turn = 1'b1;
        w.jcond = JC_TURNS;
        w.target = ST_TURN_RD;
      end
      ST_OUT_RD: begin
        w.jcond = JC_NEXT;
      end
      ST_OUT_DIFF: begin
        w.diff = 1'b1;
      end
      ST_OUT_EMIT: begin
        w.emit = 1'b1;
        w.jcond = JC_OUTS;
        w.target = ST_OUT_RD;
      end
      ST_FINISH: begin
        w.clear = 1'b1;
        w.jcond = JC_ALWAYS;
        w.target = ST_LOAD;
      end
      default: begin
        w.jcond = JC_ALWAYS;
        w.target = ST_LOAD;
      end
    endcase
    return w;
  endfunction

endpackage

// ----- rtl/rrct_ram.sv -----
module rrct_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/rrct_seq.sv -----
module rrct_seq (
  input  logic             clk,
  input  logic             rst,
  input  rrct_pkg::status_t status,
  output rrct_pkg::ctrl_t   ctrl
);
  import rrct_pkg::*;

  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;
  logic              take;

  assign ctrl = ucode(step);

  always_comb begin
    case (ctrl.jcond)
      JC_NEXT:      take = 1'b0;
      JC_ALWAYS:    take = 1'b1;
      JC_NOT_CLOSE: take = !status.load_close;
      JC_TURNS:     take = status.turns_left;
      JC_OUTS:      take = status.outs_left;
      default:      take = 1'b1;
    endcase
    step_next = take ? ctrl.target : step + STEP_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= ST_LOAD;
    end else begin
      step <= step_next;
    end
  end

endmodule

// ----- rtl/rrct_dp.sv -----
module rrct_dp #(
  parameter int MAX_JOBS = rrct_pkg::DEF_MAX_JOBS
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  rrct_pkg::ctrl_t                         ctrl,
  output rrct_pkg::status_t                       status,
  input  logic                                    start,
  input  logic [rrct_pkg::TIME_IN_W-1:0]          arrival_time,
  input  logic [rrct_pkg::TIME_IN_W-1:0]          service_time,
  input  logic                                    last_job,
  input  logic                                    cfg_we,
  input  logic [rrct_pkg::TIME_IN_W-1:0]          cfg_wdata,
  output logic                                    result_valid,
  output logic [rrct_pkg::JOB_W-1:0]              job_number,
  output logic [rrct_pkg::COMP_W-1:0]             completion_time,
  output logic signed [rrct_pkg::DIFF_W-1:0]      turnaround,
  output logic signed [rrct_pkg::DIFF_W-1:0]      waiting,
  output logic signed [rrct_pkg::TOT_W-1:0]       total_turnaround,
  output logic signed [rrct_pkg::TOT_W-1:0]       total_waiting,
  output logic                                    last_result
);
  import rrct_pkg::*;

  localparam int IDXW  = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int CNTW  = $clog2(MAX_JOBS + 1);
  localparam int TIMEW = TIME_IN_W + CNTW;
  localparam logic [CNTW-1:0] CNT_MAX = CNTW'(MAX_JOBS);
  localparam logic [CNTW-1:0] CNT_ONE = CNTW'(1);

  logic [TIME_IN_W-1:0]   quantum;
  logic [CNTW-1:0]        job_count;
  logic [TIMEW-1:0]       clock_time;
  logic [IDXW-1:0]        turn_pointer;
  logic [CNTW-1:0]        jobs_unfinished;
  logic [IDXW-1:0]        out_idx;
  logic [MAX_JOBS-1:0]    done_mask;
  logic signed [DIFF_W-1:0] tat_r;
  logic signed [DIFF_W-1:0] wt_r;
  logic signed [TOT_W-1:0]  tot_tat;
  logic signed [TOT_W-1:0]  tot_wt;

  logic [IDXW-1:0]              slot;
  logic                         load_fire;
  logic                         closing;
  logic [TIME_IN_W-1:0]         q_eff;
  logic [TIME_IN_W-1:0]         rem_rd;
  logic [2*TIME_IN_W-1:0]       job_rd;
  logic [TIMEW-1:0]             fin_rd;
  logic [TIME_IN_W-1:0]         arr_rd;
  logic [TIME_IN_W-1:0]         svc_rd;
  logic                         is_done;
  logic                         fits;
  logic [TIMEW-1:0]             finish_at;
  logic                         rem_we;
  logic [IDXW-1:0]              rem_waddr;
  logic [TIME_IN_W-1:0]         rem_wdata;
  logic                         fin_we;
  logic [CNTW-1:0]              ptr_inc;
  logic [CNTW-1:0]              out_inc;
  logic signed [TOT_W-1:0]      tot_tat_next;
  logic signed [TOT_W-1:0]      tot_wt_next;

  assign slot      = job_count[IDXW-1:0];
  assign load_fire = ctrl.load && start;
  assign closing   = last_job || (job_count + CNT_ONE == CNT_MAX);
  assign q_eff     = (quantum == '0) ? TIME_IN_W'(1) : quantum;
  assign arr_rd    = job_rd[2*TIME_IN_W-1:TIME_IN_W];
  assign svc_rd    = job_rd[TIME_IN_W-1:0];

  assign is_done   = done_mask[turn_pointer];
  assign fits      = rem_rd <= q_eff;
  assign finish_at = clock_time + TIMEW'(rem_rd);
  assign ptr_inc   = CNTW'(turn_pointer) + CNT_ONE;
  assign out_inc   = CNTW'(out_idx) + CNT_ONE;

  assign rem_we    = load_fire || (ctrl.turn && !is_done && !fits);
  assign rem_waddr = ctrl.load ? slot : turn_pointer;
  assign rem_wdata = ctrl.load ? service_time : rem_rd - q_eff;
  assign fin_we    = ctrl.turn && !is_done && fits;

  assign tot_tat_next = tot_tat + TOT_W'(tat_r);
  assign tot_wt_next  = tot_wt + TOT_W'(wt_r);

  assign status.load_close = start && closing;
  assign status.turns_left = is_done || !fits || (jobs_unfinished != CNT_ONE);
  assign status.outs_left  = out_inc != job_count;

  rrct_ram #(.WIDTH(2 * TIME_IN_W), .DEPTH(MAX_JOBS)) u_job_ram (
    .clk   (clk),
    .we    (load_fire),
    .waddr (slot),
    .wdata ({arrival_time, service_time}),
    .raddr (out_idx),
    .rdata (job_rd)
  );

  rrct_ram #(.WIDTH(TIME_IN_W), .DEPTH(MAX_JOBS)) u_rem_ram (
    .clk   (clk),
    .we    (rem_we),
    .waddr (rem_waddr),
    .wdata (rem_wdata),
    .raddr (turn_pointer),
    .rdata (rem_rd)
  );

  rrct_ram #(.WIDTH(TIMEW), .DEPTH(MAX_JOBS)) u_fin_ram (
    .clk   (clk),
    .we    (fin_we),
    .waddr (turn_pointer),
    .wdata (finish_at),
    .raddr (out_idx),
    .rdata (fin_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      quantum         <= QUANTUM_RESET;
      job_count       <= '0;
      clock_time      <= '0;
      turn_pointer    <= '0;
      jobs_unfinished <= '0;
      out_idx         <= '0;
      done_mask       <= '0;
      tot_tat         <= '0;
      tot_wt          <= '0;
      result_valid    <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      if (cfg_we) begin
        quantum <= cfg_wdata;
      end
      if (load_fire) begin
        job_count <= job_count + CNT_ONE;
      end
      if (ctrl.init) begin
        clock_time      <= '0;
        turn_pointer    <= '0;
        jobs_unfinished <= job_count;
        out_idx         <= '0;
        done_mask       <= '0;
        tot_tat         <= '0;
        tot_wt          <= '0;
      end
      if (ctrl.turn) begin
        if (!is_done) begin
          if (fits) begin
            clock_time                <= finish_at;
            done_mask[turn_pointer]   <= 1'b1;
            jobs_unfinished           <= jobs_unfinished - CNT_ONE;
          end else begin
            clock_time <= clock_time + TIMEW'(q_eff);
          end
        end
        turn_pointer <= (ptr_inc >= job_count) ? '0 : ptr_inc[IDXW-1:0];
      end
      if (ctrl.emit) begin
        tot_tat      <= tot_tat_next;
        tot_wt       <= tot_wt_next;
        out_idx      <= out_inc[IDXW-1:0];
        result_valid <= 1'b1;
      end
      if (ctrl.clear) begin
        job_count <= '0;
      end
    end
  end

  // Result payload registers.
  always_ff @(posedge clk) begin
    if (ctrl.diff) begin
      tat_r <= DIFF_W'(fin_rd) - DIFF_W'(arr_rd);
      wt_r  <= DIFF_W'(fin_rd) - DIFF_W'(arr_rd) - DIFF_W'(svc_rd);
    end
    if (ctrl.emit) begin
      job_number       <= JOB_W'(out_inc);
      completion_time  <= COMP_W'(fin_rd);
      turnaround       <= tat_r;
      waiting          <= wt_r;
      total_turnaround <= tot_tat_next;
      total_waiting    <= tot_wt_next;
      last_result      <= !status.outs_left;
    end
  end

endmodule

// ----- rtl/round_robin_completion_times.sv -----
// Round robin completion times. Jobs are loaded one word per cycle while busy is
// low: a word is taken at a clock edge with start high and busy low, and each one
// stores an arrival time and a service time. A word with last_job set, or the word
// that fills the last of MAX_JOBS slots, closes the batch. The block then raises
// busy and serves the jobs round robin in load order from time zero, granting at
// most the configured quantum per turn (a quantum of zero acts as one, and a job
// with no service finishes at its first turn without using time). Each visited slot
// has a read step, which reads the remaining service from memory, and an update
// step, and slots of finished jobs are still visited on later passes. After the
// schedule, one result word per job follows in load order, each made in a memory
// read step, a difference step and an accumulate step, and each held for exactly
// one cycle with result_valid high; the receiver cannot stall the block and
// must take every word as it appears. After the closing word the block therefore
// passes a setup step, the visited slots, the result words and a final step
// before the next batch can be loaded. The totals restart from zero with every
// batch, and the host divides them by the job count for averages. The quantum
// may only be written while busy is low.
module round_robin_completion_times #(
  parameter int MAX_JOBS = rrct_pkg::DEF_MAX_JOBS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [rrct_pkg::TIME_IN_W-1:0]      arrival_time,
  input  logic [rrct_pkg::TIME_IN_W-1:0]      service_time,
  input  logic                                last_job,
  input  logic                                cfg_we,
  input  logic [rrct_pkg::TIME_IN_W-1:0]      cfg_wdata,
  output logic                                result_valid,
  output logic [rrct_pkg::JOB_W-1:0]          job_number,
  output logic [rrct_pkg::COMP_W-1:0]         completion_time,
  output logic signed [rrct_pkg::DIFF_W-1:0]  turnaround,
  output logic signed [rrct_pkg::DIFF_W-1:0]  waiting,
  output logic signed [rrct_pkg::TOT_W-1:0]   total_turnaround,
  output logic signed [rrct_pkg::TOT_W-1:0]   total_waiting,
  output logic                                last_result
);
  import rrct_pkg::*;

  ctrl_t   ctrl;
  status_t status;

  // Busy is simply the control word's busy bit: only the load step takes words.
  assign busy = ctrl.busy;

  // The sequencer steps through the microprogram and jumps on datapath status.
  rrct_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl)
  );

  // The datapath holds the job memories, the schedule counters and the result
  // registers; every action in it but the quantum write is enabled by a bit of the current control word.
  rrct_dp #(.MAX_JOBS(MAX_JOBS)) u_dp (
    .clk              (clk),
    .rst              (rst),
    .ctrl             (ctrl),
    .status           (status),
    .start            (start),
    .arrival_time     (arrival_time),
    .service_time     (service_time),
    .last_job         (last_job),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .result_valid     (result_valid),
    .job_number       (job_number),
    .completion_time  (completion_time),
    .turnaround       (turnaround),
    .waiting          (waiting),
    .total_turnaround (total_turnaround),
    .total_waiting    (total_waiting),
    .last_result      (last_result)
  );

endmodule

// ----- test/round_robin_completion_times_test.sv -----
`timescale 1ns / 100ps

module round_robin_completion_times_test;
  import rrct_pkg::*;

  localparam int MAX_JOBS = DEF_MAX_JOBS;

  // The longest stretch with no word moving in either direction is the
  // schedule of one job that needs 65535 units under a quantum of one, where
  // every turn visits the slot in a read step and an update step. The limit
  // is several times as long as that walk.
  localparam int SILENCE_LIMIT = 500000;

  // In wide batches the service times span the full 16 bits. A quantum of at
  // least this value keeps such a batch to 16 passes over the slots.
  localparam int WIDE_QUANTUM_MIN = 4096;

  // One result word as the block should emit it. The difference fields and
  // the totals are signed, like the ports, so that both sides widen the same
  // way when they are compared.
  typedef struct {
    logic [JOB_W-1:0]         job_number;
    logic [COMP_W-1:0]        completion_time;
    logic signed [DIFF_W-1:0] turnaround;
    logic signed [DIFF_W-1:0] waiting;
    logic signed [TOT_W-1:0]  total_turnaround;
    logic signed [TOT_W-1:0]  total_waiting;
    logic                     last_result;
  } completion_t;

  logic                     clk;
  logic                     rst;
  logic                     start;
  logic                     busy;
  logic [TIME_IN_W-1:0]     arrival_time;
  logic [TIME_IN_W-1:0]     service_time;
  logic                     last_job;
  logic                     cfg_we;
  logic [TIME_IN_W-1:0]     cfg_wdata;
  logic                     result_valid;
  logic [JOB_W-1:0]         job_number;
  logic [COMP_W-1:0]        completion_time;
  logic signed [DIFF_W-1:0] turnaround;
  logic signed [DIFF_W-1:0] waiting;
  logic signed [TOT_W-1:0]  total_turnaround;
  logic signed [TOT_W-1:0]  total_waiting;
  logic                     last_result;

  // Predictor state: the quantum the block holds, and the jobs loaded into
  // the batch that is still open.
  logic [TIME_IN_W-1:0] quantum_model;
  int unsigned          loaded_arrival [MAX_JOBS];
  int unsigned          loaded_service [MAX_JOBS];
  int                   loaded_count;

  // Completions still owed by the block, oldest first.
  completion_t pending_completions [$];
  completion_t oldest_completion;

  bit idle_enable;
  int errors;
  int words_sent;
  int batches_closed;
  int results_checked;
  int silent_cycles;

  round_robin_completion_times #(
    .MAX_JOBS(MAX_JOBS)
  ) dut (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .arrival_time     (arrival_time),
    .service_time     (service_time),
    .last_job         (last_job),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .result_valid     (result_valid),
    .job_number       (job_number),
    .completion_time  (completion_time),
    .turnaround       (turnaround),
    .waiting          (waiting),
    .total_turnaround (total_turnaround),
    .total_waiting    (total_waiting),
    .last_result      (last_result)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Serves the open batch round robin, exactly as the block should, and
  // queues one completion per job in load order. Slots of finished jobs are
  // still passed over, and a job with no service left finishes at its turn
  // without moving the clock. A quantum of zero behaves as one.
  task automatic predict_completions();
    int unsigned slice;
    int unsigned clock_now;
    int unsigned jobs_left;
    int unsigned slot;
    int unsigned remaining [MAX_JOBS];
    int unsigned finished_at [MAX_JOBS];
    bit          finished [MAX_JOBS];
    longint      tat;
    longint      wt;
    longint      sum_tat;
    longint      sum_wt;
    completion_t c;
    slice = (quantum_model == 0) ? 1 : 32'(quantum_model);
    clock_now = 0;
    jobs_left = loaded_count;
    slot = 0;
    sum_tat = 0;
    sum_wt = 0;
    for (int i = 0; i < loaded_count; i++) begin
      remaining[i] = loaded_service[i];
      finished[i] = 1'b0;
    end
    while (jobs_left > 0) begin
      if (!finished[slot]) begin
        if (remaining[slot] <= slice) begin
          clock_now += remaining[slot];
          finished_at[slot] = clock_now;
          finished[slot] = 1'b1;
          jobs_left--;
        end else begin
          remaining[slot] -= slice;
          clock_now += slice;
        end
      end
      slot = (slot + 1 >= loaded_count) ? 0 : slot + 1;
    end
    // Arrival never gates service; it only comes off afterwards, so both
    // turnaround and waiting can go negative.
    for (int i = 0; i < loaded_count; i++) begin
      tat = longint'(finished_at[i]) - longint'(loaded_arrival[i]);
      wt = tat - longint'(loaded_service[i]);
      sum_tat += tat;
      sum_wt += wt;
      c.job_number = JOB_W'(i + 1);
      c.completion_time = COMP_W'(finished_at[i]);
      c.turnaround = DIFF_W'(tat);
      c.waiting = DIFF_W'(wt);
      c.total_turnaround = TOT_W'(sum_tat);
      c.total_waiting = TOT_W'(sum_wt);
      c.last_result = (i == loaded_count - 1);
      pending_completions.push_back(c);
    end
    loaded_count = 0;
    batches_closed++;
  endtask

  // Presents one job word and holds it until the block takes it. Before the
  // word the line may idle for a few cycles, with random values on the data
  // ports that the block must ignore. The task returns at the edge that
  // accepted the word, with start still high, so that a following word can
  // go out at the very next cycle.
  task automatic send_job(input logic [TIME_IN_W-1:0] arrival,
                          input logic [TIME_IN_W-1:0] service,
                          input logic                 closes_batch);
    @(negedge clk);
    while (idle_enable && $urandom_range(99) < 22) begin
      start <= 1'b0;
      arrival_time <= TIME_IN_W'($urandom_range(0, 65535));
      service_time <= TIME_IN_W'($urandom_range(0, 65535));
      last_job <= 1'($urandom_range(1));
      @(negedge clk);
    end
    start <= 1'b1;
    arrival_time <= arrival;
    service_time <= service;
    last_job <= closes_batch;
    @(posedge clk);
    while (busy) @(posedge clk);
    loaded_arrival[loaded_count] = 32'(arrival);
    loaded_service[loaded_count] = 32'(service);
    loaded_count++;
    words_sent++;
    // A word that fills the last slot closes the batch just as last_job does.
    if (closes_batch || loaded_count == MAX_JOBS) predict_completions();
  endtask

  // Drops start and waits until every owed completion has come out. The
  // block clears its count in the cycle that shows its last result word, and
  // the task waits on past that clear before anything else is driven.
  task automatic wait_batches_done();
    @(negedge clk);
    start <= 1'b0;
    while (pending_completions.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // The quantum may only change while the block is idle.
  task automatic write_quantum(input logic [TIME_IN_W-1:0] value);
    wait_batches_done();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    quantum_model = value;
    @(negedge clk);
    cfg_we <= 1'b0;
    cfg_wdata <= TIME_IN_W'($urandom_range(0, 65535));
  endtask

  task automatic check_field(input string       field,
                             input int unsigned job,
                             input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: job %0d %s mismatch: expected %0h, actual %0h",
               $time, job, field, want, got);
      errors++;
    end
  endtask

  // Every result word is valid for exactly one cycle and is taken at the
  // edge that ends it; it is matched against the oldest completion owed.
  always @(posedge clk) begin
    if (!rst && result_valid) begin
      if (pending_completions.size() == 0) begin
        $display("%0t: unexpected result word: expected none, actual job %0d",
                 $time, job_number);
        errors++;
      end else begin
        oldest_completion = pending_completions.pop_front();
        check_field("job_number", 32'(oldest_completion.job_number),
                    32'(oldest_completion.job_number), 32'(job_number));
        check_field("completion_time", 32'(oldest_completion.job_number),
                    32'(oldest_completion.completion_time), 32'(completion_time));
        check_field("turnaround", 32'(oldest_completion.job_number),
                    32'(oldest_completion.turnaround), 32'(turnaround));
        check_field("waiting", 32'(oldest_completion.job_number),
                    32'(oldest_completion.waiting), 32'(waiting));
        check_field("total_turnaround", 32'(oldest_completion.job_number),
                    32'(oldest_completion.total_turnaround), 32'(total_turnaround));
        check_field("total_waiting", 32'(oldest_completion.job_number),
                    32'(oldest_completion.total_waiting), 32'(total_waiting));
        check_field("last_result", 32'(oldest_completion.job_number),
                    32'(oldest_completion.last_result), 32'(last_result));
        results_checked++;
      end
    end
  end

  // Watchdog: any accepted word, in or out, restarts the count.
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid) begin
      silent_cycles <= 0;
    end else begin
      silent_cycles <= silent_cycles + 1;
      if (silent_cycles >= SILENCE_LIMIT) begin
        $display("%0t: no word moved for %0d cycles, %0d completions still owed",
                 $time, SILENCE_LIMIT, pending_completions.size());
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // A small batch under the quantum that reset leaves behind, with a job
  // that needs no service at all in the middle.
  task automatic test_reset_quantum();
    send_job(16'd0, 16'd10, 1'b0);
    send_job(16'd2, 16'd0, 1'b0);
    send_job(16'd5, 16'd7, 1'b1);
  endtask

  // Single-job batches at the ends of the time fields, which drive the
  // turnaround and the waiting time to zero and to their most negative.
  task automatic test_time_extremes();
    write_quantum(16'hFFFF);
    send_job(16'hFFFF, 16'hFFFF, 1'b1);
    send_job(16'hFFFF, 16'd0, 1'b1);
    send_job(16'd0, 16'hFFFF, 1'b1);
  endtask

  // Sixteen jobs of full service and last_job never set: the word that fills
  // the last slot must close the batch. Completion and totals reach their top.
  task automatic test_full_capacity();
    for (int i = 0; i < MAX_JOBS; i++) begin
      send_job((i % 2 == 0) ? 16'd0 : 16'hFFFF, 16'hFFFF, 1'b0);
    end
  endtask

  // A quantum of zero must act as a quantum of one.
  task automatic test_zero_quantum();
    write_quantum(16'd0);
    send_job(16'd1, 16'd3, 1'b0);
    send_job(16'd0, 16'd2, 1'b1);
  endtask

  // The slowest schedule the run uses: one full-length job in unit slices.
  task automatic test_unit_quantum_long_job();
    write_quantum(16'd1);
    send_job(16'd0, 16'hFFFF, 1'b1);
  endtask

  // Random batches of random size. Narrow batches keep service times short
  // under a small quantum, which makes for many turns; wide batches use the
  // full service range under a large quantum. Between batches with the same
  // quantum the next word is already waiting while the block is busy. A
  // stretch in the middle runs with no idle cycles on the input.
  task automatic test_random_batches(input int target);
    int          sent;
    int          batch_size;
    int          quiet_from;
    int          quiet_to;
    bit          wide;
    logic [TIME_IN_W-1:0] arrival;
    logic [TIME_IN_W-1:0] service;
    logic        closes;
    sent = 0;
    wide = 1'b0;
    quiet_from = target / 3;
    quiet_to = quiet_from + 100;
    while (sent < target) begin
      if ($urandom_range(1) == 1) begin
        wide = ($urandom_range(99) < 25);
        if (wide) begin
          case ($urandom_range(2))
            0: write_quantum(16'hFFFF);
            1: write_quantum(TIME_IN_W'(WIDE_QUANTUM_MIN));
            default: write_quantum(TIME_IN_W'($urandom_range(WIDE_QUANTUM_MIN, 65535)));
          endcase
        end else begin
          write_quantum(TIME_IN_W'($urandom_range(0, 12)));
        end
      end
      batch_size = ($urandom_range(99) < 70) ? $urandom_range(1, 6)
                                             : $urandom_range(7, MAX_JOBS);
      for (int i = 0; i < batch_size; i++) begin
        idle_enable = !(sent >= quiet_from && sent < quiet_to);
        service = wide ? TIME_IN_W'($urandom_range(0, 65535))
                       : TIME_IN_W'($urandom_range(0, 40));
        arrival = ($urandom_range(3) == 0) ? TIME_IN_W'($urandom_range(0, 64))
                                           : TIME_IN_W'($urandom_range(0, 65535));
        // A full batch may or may not carry last_job on its final word.
        if (i != batch_size - 1) closes = 1'b0;
        else if (batch_size == MAX_JOBS) closes = 1'($urandom_range(1));
        else closes = 1'b1;
        send_job(arrival, service, closes);
        sent++;
      end
    end
    idle_enable = 1'b1;
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    arrival_time = '0;
    service_time = '0;
    last_job = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    quantum_model = QUANTUM_RESET;
    loaded_count = 0;
    idle_enable = 1'b1;
    errors = 0;
    words_sent = 0;
    batches_closed = 0;
    results_checked = 0;
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    test_reset_quantum();
    test_time_extremes();
    test_full_capacity();
    test_zero_quantum();
    test_unit_quantum_long_job();
    test_random_batches(370);

    // Let the last batch drain, then give the block time to show any
    // stray result word.
    wait_batches_done();
    repeat (20) @(posedge clk);

    $display("Loaded %0d job words in %0d batches and checked %0d completions.",
             words_sent, batches_closed, results_checked);
    $display("Quanta from 0 to 65535, zero and full service, full batches of %0d jobs.",
             MAX_JOBS);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
